@@ rtl/min_coin_change_dp_macros.svh @@
// Assertion macros for the min_coin_change_dp checker.
// No dependencies; included by the checker file only.
`ifndef MIN_COIN_CHANGE_DP_MACROS_SVH
`define MIN_COIN_CHANGE_DP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_coin_change_dp: assertion failed");

// Next-cycle implication, disabled during reset.
`define MCCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_coin_change_dp: assertion failed");

`endif

@@ rtl/mccd_pkg.sv @@
// Shared types, constants and the control store of the coin change sequencer.
// No dependencies; used by mccd_seq and min_coin_change_dp.
package mccd_pkg;

    localparam int CNT_W         = 10;   // coin count / amount width
    localparam int ENTRY_W       = 11;   // table entry: reach bit + count
    localparam int REACH_BIT     = 10;
    localparam int COINS_W       = 3;
    localparam int NUM_COIN_REGS = 6;
    localparam int CFG_IDX_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COIN_VALUE_0 = 3'd1;

    // step codes
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_COIN  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WRITE = 3'd3;
    localparam logic [STEP_W-1:0] STEP_RDT   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd5;

    // jump conditions
    localparam logic [2:0] JC_NEXT       = 3'd0;
    localparam logic [2:0] JC_ALWAYS     = 3'd1;
    localparam logic [2:0] JC_NOSTART    = 3'd2;
    localparam logic [2:0] JC_OOR        = 3'd3;
    localparam logic [2:0] JC_COINS_LEFT = 3'd4;
    localparam logic [2:0] JC_JNOTDONE   = 3'd5;

    typedef struct packed {
        logic [2:0]        jc;
        logic [STEP_W-1:0] jt;
        logic              latch;   // take a new query (gated by start)
        logic              issue;   // look up table at j - coin[i]
        logic              wr;      // write entry j
        logic              nextj;   // advance j, restart coin scan
        logic              rdt;     // read entry at target
        logic              emit;    // register the result
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic oor;
        logic coins_left;
        logic j_done;
    } cond_t;

    function automatic ctrl_t ctrl_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.jc = JC_NOSTART; w.jt = STEP_IDLE; w.latch = 1'b1;
            end
            STEP_CHECK:
            begin
                w.jc = JC_OOR; w.jt = STEP_EMIT;
            end
            STEP_COIN:
            begin
                w.jc = JC_COINS_LEFT; w.jt = STEP_COIN; w.issue = 1'b1;
            end
            STEP_WRITE:
            begin
                w.jc = JC_JNOTDONE; w.jt = STEP_COIN; w.wr = 1'b1; w.nextj = 1'b1;
            end
            STEP_RDT:
            begin
                w.jc = JC_NEXT; w.jt = STEP_IDLE; w.rdt = 1'b1;
            end
            STEP_EMIT:
            begin
                w.jc = JC_ALWAYS; w.jt = STEP_IDLE; w.emit = 1'b1;
            end
            default:
            begin
                w.jc = JC_ALWAYS; w.jt = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/mccd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mccd_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mccd_seq.sv @@
// Microcode sequencer: step counter, control store lookup, conditional jumps.
// Depends on mccd_pkg.
module mccd_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  mccd_pkg::cond_t cond,
    output mccd_pkg::ctrl_t ctrl,
    output logic            busy
);
    import mccd_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign ctrl = ctrl_word(step_reg);

    always_comb
    begin
        unique case (ctrl.jc)
            JC_NEXT:       taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NOSTART:    taken = !cond.start;
            JC_OOR:        taken = cond.oor;
            JC_COINS_LEFT: taken = cond.coins_left;
            JC_JNOTDONE:   taken = !cond.j_done;
            default:       taken = 1'b1;
        endcase
        step_next = taken ? ctrl.jt : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != STEP_IDLE);

endmodule

@@ rtl/min_coin_change_dp.sv @@
// Minimum coin change: microcoded datapath around a bottom-up table RAM.
// Depends on mccd_pkg, mccd_seq and mccd_ram.
//
// A query is taken when start is high and busy is low. The block fills its
// table from amount 0 up to target_amount; each entry scans the coins in use,
// one lookup per cycle on the table RAM's single read port, then takes a
// scan tail step and the write. After the last entry the target entry is
// read back and the result registered. A target above MAX_AMOUNT skips the
// fill and is answered unreachable without touching the table.
// The result word sits on fewest_coins/reachable for exactly one cycle with
// done high; the receiver cannot stall it, and the next query may be started
// in that same cycle. Unreachable amounts read fewest_coins = 0. The table
// needs no clearing after reset: every entry is written before it is read.
// Configuration writes (cfg_ready is always high) must only be made while
// busy is low; cfg_index 0 is the coin count, 1..6 the coin values, other
// indexes are ignored.
module min_coin_change_dp #(
    parameter int MAX_AMOUNT = 1023,
    parameter int MAX_COINS  = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [9:0] target_amount,
    output logic       done,
    output logic [9:0] fewest_coins,
    output logic       reachable,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data
);
    import mccd_pkg::*;

    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(DEPTH);
    // usable coin registers: bounded by the parameter and the register file
    localparam int NC    = (MAX_COINS < NUM_COIN_REGS) ? MAX_COINS : NUM_COIN_REGS;

    // configuration registers
    logic [COINS_W-1:0] coin_count_reg;
    logic [CNT_W-1:0]   coin_value_reg [NUM_COIN_REGS];
    logic [COINS_W-1:0] ncoins;
    logic [CFG_IDX_W-1:0] coin_slot;

    // datapath registers
    logic [CNT_W-1:0]   target_reg;
    logic               oor_reg;
    logic [CNT_W-1:0]   j_reg;
    logic [COINS_W-1:0] i_reg;
    logic [CNT_W-1:0]   best_reg;
    logic               found_reg;
    logic               pend_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   fewest_reg;
    logic               reach_reg;

    logic [CNT_W-1:0]   coin_sel;
    logic               coins_left;
    logic               usable;
    logic               accept;
    logic               better;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    cond_t cond;
    ctrl_t ctrl;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign coin_slot = cfg_index - CFG_COIN_VALUE_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= '0;
            for (int k = 0; k < NUM_COIN_REGS; k++)
            begin
                coin_value_reg[k] <= CNT_W'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_COIN_COUNT)
            begin
                coin_count_reg <= cfg_data[COINS_W-1:0];
            end
            else if (32'(coin_slot) < NUM_COIN_REGS)
            begin
                coin_value_reg[coin_slot] <= cfg_data;
            end
        end
    end

    // saturate the coin count
    assign ncoins = (32'(coin_count_reg) > NC) ? COINS_W'(NC) : coin_count_reg;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign accept          = ctrl.latch && start;
    assign cond.start      = start;
    assign cond.oor        = oor_reg;
    assign cond.coins_left = coins_left;
    assign cond.j_done     = (j_reg == target_reg);

    mccd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    //------------------------------------------------------------------
    // Coin scan
    //------------------------------------------------------------------
    always_comb
    begin
        coin_sel = '0;
        for (int k = 0; k < NUM_COIN_REGS; k++)
        begin
            if (32'(i_reg) == k)
            begin
                coin_sel = coin_value_reg[k];
            end
        end
    end

    assign coins_left = (i_reg < ncoins);
    // zero coins and coins larger than j are skipped
    assign usable     = coins_left && (coin_sel != '0) && (coin_sel <= j_reg);

    // lookup result from the previous cycle competes for the minimum
    assign better = pend_reg && ram_rdata[REACH_BIT] &&
                    (!found_reg || (ram_rdata[CNT_W-1:0] < best_reg));

    //------------------------------------------------------------------
    // Table RAM
    //------------------------------------------------------------------
    assign ram_we    = ctrl.wr;
    assign ram_waddr = AW'(j_reg);
    assign ram_raddr = ctrl.rdt ? AW'(target_reg) : AW'(j_reg - coin_sel);

    always_comb
    begin
        if (j_reg == '0)
        begin
            ram_wdata = {1'b1, {CNT_W{1'b0}}};
        end
        else if (found_reg)
        begin
            ram_wdata = {1'b1, best_reg + 1'b1};
        end
        else
        begin
            ram_wdata = '0;
        end
    end

    mccd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    //------------------------------------------------------------------
    // Datapath control state
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            found_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= ctrl.issue && usable;
            done_reg <= ctrl.emit;

            if (accept || ctrl.nextj)
            begin
                i_reg     <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ctrl.issue && coins_left)
                begin
                    i_reg <= i_reg + 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= target_amount;
            oor_reg    <= (32'(target_amount) > MAX_AMOUNT);
            j_reg      <= '0;
        end
        else if (ctrl.nextj)
        begin
            j_reg <= j_reg + 1'b1;
        end

        if (better)
        begin
            best_reg <= ram_rdata[CNT_W-1:0];
        end

        if (ctrl.emit)
        begin
            reach_reg  <= !oor_reg && ram_rdata[REACH_BIT];
            fewest_reg <= (!oor_reg && ram_rdata[REACH_BIT]) ? ram_rdata[CNT_W-1:0] : '0;
        end
    end

    assign done         = done_reg;
    assign fewest_coins = fewest_reg;
    assign reachable    = reach_reg;

endmodule

@@ rtl/min_coin_change_dp_checker.sv @@
// Port-level checker for min_coin_change_dp, bound to the top level.
// Depends on min_coin_change_dp_macros.svh.
`include "min_coin_change_dp_macros.svh"

module min_coin_change_dp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [9:0] fewest_coins,
    input logic       reachable
);

    // an accepted query keeps the block busy in the next cycle
    `MCCD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // a result word is a single-cycle strobe
    `MCCD_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)

    // results appear only once the query has finished, right after busy
    `MCCD_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy && $past(busy))

    // unreachable amounts report zero coins
    `MCCD_ASSERT_IMP(a_unreach_zero, clk, rst_n, done && !reachable, fewest_coins == 10'd0)

endmodule

bind min_coin_change_dp min_coin_change_dp_checker u_chk (.*);
